// File: src/sbsc_pkg.sv
// ----------------------------------------------------------------------------
// sbsc_pkg
// Shared widths, constants and types of the segment versus box clipping core.
// ----------------------------------------------------------------------------
package sbsc_pkg;

	localparam int COORD_W = 24;              // signed Q16.8 coordinate
	localparam int SIZE_W  = 23;              // unsigned Q15.8 box extent
	localparam int DELTA_W = COORD_W + 1;     // end minus start
	localparam int NUM_W   = COORD_W + 3;     // doubled-scale slab distances
	localparam int PROD_W  = 2 * NUM_W;       // cross products
	localparam int FRAC_W  = 17;              // unsigned Q1.16 fraction
	localparam int FRAC_ONE = 65536;
	localparam int REM_W   = NUM_W;           // divider remainder and divisor
	localparam int DIV_STAGES = FRAC_W;       // one quotient bit per stage

	typedef struct packed {
		logic signed [NUM_W-1:0] n;
		logic signed [NUM_W-1:0] d;
	} ratio_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] en_n;
		logic signed [NUM_W-1:0] ex_n;
		logic signed [NUM_W-1:0] den;
		logic                    par;
		logic                    in_slab;
	} slab_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
	} geom_t;

endpackage

// File: src/sbsc_slab.sv
// ----------------------------------------------------------------------------
// sbsc_slab
// Slab setup for both axes and clipping of the unit interval against x.
// ----------------------------------------------------------------------------
module sbsc_slab
	import sbsc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic signed [COORD_W-1:0] box_center_x,
	input  logic signed [COORD_W-1:0] box_center_y,
	input  logic        [SIZE_W-1:0]  box_width,
	input  logic        [SIZE_W-1:0]  box_height,
	output logic                      out_valid,
	input  logic                      out_ready,
	output geom_t                     geom,
	output ratio_t                    lo,
	output ratio_t                    hi,
	output logic                      ok_x,
	output slab_t                     slab_y
);

	logic   v_s1, v_s2, rdy_s1, rdy_s2;
	geom_t  geo_c, geo_s1, geo_s2;
	slab_t  sx_c, sy_c, slx_s1, sly_s1, sly_s2;
	ratio_t lo_c, hi_c, lo_s2, hi_s2;
	logic   ok_c, ok_s2;

	function automatic slab_t make_slab(input logic signed [COORD_W-1:0] s,
			input logic signed [DELTA_W-1:0] d,
			input logic signed [COORD_W-1:0] c,
			input logic [SIZE_W-1:0] size);
		logic signed [NUM_W-1:0] c2, s2, sz, near2, far2, d2;
		slab_t r;
		c2 = {{2{c[COORD_W-1]}}, c, 1'b0};
		s2 = {{2{s[COORD_W-1]}}, s, 1'b0};
		sz = {{(NUM_W-SIZE_W){1'b0}}, size};
		d2 = {d[DELTA_W-1], d, 1'b0};
		near2 = c2 - sz - s2;
		far2 = c2 + sz - s2;
		r.par = (d == '0);
		r.in_slab = (near2 <= 0) && (far2 >= 0);
		if (d > 0) begin
			r.en_n = near2;
			r.ex_n = far2;
			r.den = d2;
		end else begin
			r.en_n = -far2;
			r.ex_n = -near2;
			r.den = -d2;
		end
		return r;
	endfunction

	always_comb begin
		geo_c.sx = start_x;
		geo_c.sy = start_y;
		geo_c.dx = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
		geo_c.dy = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
		sx_c = make_slab(start_x, geo_c.dx, box_center_x, box_width);
		sy_c = make_slab(start_y, geo_c.dy, box_center_y, box_height);
	end

	// Against the starting interval [0,1] every cross product collapses to a
	// plain comparison of numerator and denominator.
	always_comb begin
		lo_c.n = '0;
		lo_c.d = NUM_W'(1);
		hi_c.n = NUM_W'(1);
		hi_c.d = NUM_W'(1);
		if (slx_s1.par) begin
			ok_c = slx_s1.in_slab;
		end else begin
			ok_c = !(slx_s1.ex_n < 0) && !(slx_s1.den < slx_s1.en_n);
			if (slx_s1.en_n > 0) begin
				lo_c.n = slx_s1.en_n;
				lo_c.d = slx_s1.den;
			end
			if (slx_s1.ex_n < slx_s1.den) begin
				hi_c.n = slx_s1.ex_n;
				hi_c.d = slx_s1.den;
			end
		end
	end

	assign rdy_s2 = !v_s2 || out_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			geo_s1 <= geo_c;
			slx_s1 <= sx_c;
			sly_s1 <= sy_c;
		end
		if (v_s1 && rdy_s2) begin
			geo_s2 <= geo_s1;
			sly_s2 <= sly_s1;
			lo_s2 <= lo_c;
			hi_s2 <= hi_c;
			ok_s2 <= ok_c;
		end
	end

	assign out_valid = v_s2;
	assign geom = geo_s2;
	assign lo = lo_s2;
	assign hi = hi_s2;
	assign ok_x = ok_s2;
	assign slab_y = sly_s2;

endmodule

// File: src/sbsc_yclip.sv
// ----------------------------------------------------------------------------
// sbsc_yclip
// Clips the interval against the y slab by cross multiplication.
// ----------------------------------------------------------------------------
module sbsc_yclip
	import sbsc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  geom_t  geom_in,
	input  ratio_t lo_in,
	input  ratio_t hi_in,
	input  logic   ok_x,
	input  slab_t  slab_y,
	output logic   out_valid,
	input  logic   out_ready,
	output geom_t  geom,
	output ratio_t lo,
	output logic   hit
);

	logic   v_s1, v_s2, rdy_s1, rdy_s2;
	logic signed [PROD_W-1:0] exlo_a_s1, lod_b_s1, hien_a_s1, enhi_b_s1;
	logic signed [PROD_W-1:0] enlo_b_s1;
	geom_t  geo_s1, geo_s2;
	ratio_t lo_s1, lo_s2, en_s1;
	logic   ok_s1, par_s1, ins_s1, hit_s2;
	logic   miss_c, take_c;

	// lo.n * den_y serves both the exit-before-low and the low-before-entry test.
	// Once both miss tests pass, the narrowed interval cannot be empty, so the
	// high bound is not carried any further.
	always_comb begin
		miss_c = (exlo_a_s1 < lod_b_s1) || (hien_a_s1 < enhi_b_s1);
		take_c = !par_s1 && (lod_b_s1 < enlo_b_s1);
	end

	assign rdy_s2 = !v_s2 || out_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			exlo_a_s1 <= slab_y.ex_n * lo_in.d;
			lod_b_s1  <= lo_in.n * slab_y.den;
			hien_a_s1 <= hi_in.n * slab_y.den;
			enhi_b_s1 <= slab_y.en_n * hi_in.d;
			enlo_b_s1 <= slab_y.en_n * lo_in.d;
			geo_s1 <= geom_in;
			lo_s1 <= lo_in;
			en_s1.n <= slab_y.en_n;
			en_s1.d <= slab_y.den;
			ok_s1 <= ok_x;
			par_s1 <= slab_y.par;
			ins_s1 <= slab_y.in_slab;
		end
		if (v_s1 && rdy_s2) begin
			geo_s2 <= geo_s1;
			lo_s2 <= take_c ? en_s1 : lo_s1;
			hit_s2 <= ok_s1 && (par_s1 ? ins_s1 : !miss_c);
		end
	end

	assign out_valid = v_s2;
	assign geom = geo_s2;
	assign lo = lo_s2;
	assign hit = hit_s2;

endmodule

// File: src/sbsc_div.sv
// ----------------------------------------------------------------------------
// sbsc_div
// Pipelined restoring divider: rounds lo.n / lo.d to a Q1.16 fraction.
// ----------------------------------------------------------------------------
module sbsc_div
	import sbsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  geom_t             geom_in,
	input  ratio_t            lo,
	input  logic              hit_in,
	output logic              out_valid,
	input  logic              out_ready,
	output geom_t             geom,
	output logic [FRAC_W-1:0] quo,
	output logic              hit
);

	// The dividend is lo.n * 2^17 + lo.d over 2 * lo.d, which rounds halves up.
	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES:0]   rdy;
	logic [REM_W-1:0]      rem_s [DIV_STAGES];
	logic [FRAC_W-1:0]     nlo_s [DIV_STAGES];
	logic [FRAC_W-1:0]     quo_s [DIV_STAGES];
	logic [REM_W-1:0]      dsr_s [DIV_STAGES];
	logic                  hit_s [DIV_STAGES];
	geom_t                 geo_s [DIV_STAGES];

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		logic              v_in;
		logic [REM_W-1:0]  r_in, d_in, r_out;
		logic [FRAC_W-1:0] n_in, q_in;
		logic              h_in;
		geom_t             g_in;
		logic [REM_W:0]    trial;
		logic              qbit;

		if (k == 0) begin : g_front
			assign v_in = in_valid;
			assign r_in = REM_W'(lo.n) + REM_W'(lo.d >>> FRAC_W);
			assign n_in = lo.d[FRAC_W-1:0];
			assign d_in = REM_W'({lo.d, 1'b0});
			assign q_in = '0;
			assign h_in = hit_in;
			assign g_in = geom_in;
		end else begin : g_chain
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign n_in = nlo_s[k-1];
			assign d_in = dsr_s[k-1];
			assign q_in = quo_s[k-1];
			assign h_in = hit_s[k-1];
			assign g_in = geo_s[k-1];
		end

		always_comb begin
			trial = {r_in, n_in[FRAC_W-1]};
			qbit = (trial >= {1'b0, d_in});
			r_out = qbit ? REM_W'(trial - {1'b0, d_in}) : trial[REM_W-1:0];
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (v_in && rdy[k]) begin
				rem_s[k] <= r_out;
				nlo_s[k] <= {n_in[FRAC_W-2:0], 1'b0};
				dsr_s[k] <= d_in;
				quo_s[k] <= {q_in[FRAC_W-2:0], qbit};
				hit_s[k] <= h_in;
				geo_s[k] <= g_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign geom = geo_s[DIV_STAGES-1];
	assign quo = quo_s[DIV_STAGES-1];
	assign hit = hit_s[DIV_STAGES-1];

endmodule

// File: src/sbsc_point.sv
// ----------------------------------------------------------------------------
// sbsc_point
// Clamps the fraction and forms the rounded entry point on both axes.
// ----------------------------------------------------------------------------
module sbsc_point
	import sbsc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  geom_t                     geom,
	input  logic [FRAC_W-1:0]         quo,
	input  logic                      hit_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic [FRAC_W-1:0]         entry_fraction,
	output logic signed [COORD_W-1:0] hit_x,
	output logic signed [COORD_W-1:0] hit_y
);

	localparam int PW = DELTA_W + FRAC_W + 1;

	logic v_s1, v_s2, rdy_s1, rdy_s2;
	logic [FRAC_W-1:0] f_c, f_s1, f_s2;
	logic signed [PW-1:0] px_s1, py_s1, rx_c, ry_c;
	logic signed [COORD_W-1:0] sx_s1, sy_s1, hx_s2, hy_s2;
	logic hit_s1, hit_s2;

	assign f_c = (quo > FRAC_W'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE) : quo;

	// Adding a half and taking bits 16 and up is a floor of the rounded value.
	assign rx_c = px_s1 + PW'(FRAC_ONE / 2);
	assign ry_c = py_s1 + PW'(FRAC_ONE / 2);

	assign rdy_s2 = !v_s2 || out_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			px_s1 <= geom.dx * $signed({1'b0, f_c});
			py_s1 <= geom.dy * $signed({1'b0, f_c});
			sx_s1 <= geom.sx;
			sy_s1 <= geom.sy;
			f_s1 <= f_c;
			hit_s1 <= hit_in;
		end
		if (v_s1 && rdy_s2) begin
			hit_s2 <= hit_s1;
			f_s2 <= hit_s1 ? f_s1 : '0;
			hx_s2 <= hit_s1 ? sx_s1 + rx_c[COORD_W+15:16] : '0;
			hy_s2 <= hit_s1 ? sy_s1 + ry_c[COORD_W+15:16] : '0;
		end
	end

	assign out_valid = v_s2;
	assign hit = hit_s2;
	assign entry_fraction = f_s2;
	assign hit_x = hx_s2;
	assign hit_y = hy_s2;

endmodule

// File: src/segment_box_slab_clip_core.sv
// ----------------------------------------------------------------------------
// segment_box_slab_clip_core
// Segment versus axis-aligned box overlap test by slab clipping.
// ----------------------------------------------------------------------------
// Each transfer on the slave side carries one segment and one box; exactly one
// result transfer follows on the master side, in order. The core is fully
// pipelined and accepts one item in every cycle while the master side does
// not stall. Its steps are slab setup and the x clip, the y cross products
// and compare, the divider that yields one bit of the entry fraction per
// stage, and the entry point multiply and rounding. Every stage holds its
// own valid bit, so a stall on the master side lets empty stages fill before
// the slave side is held off. A segment that only touches the box counts as
// a hit, a segment parallel to an axis misses unless its start lies in that
// slab, and on a miss all result fields are zero.
// ----------------------------------------------------------------------------
module segment_box_slab_clip_core
	import sbsc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72],
	// box_center_x[119:96], box_center_y[143:120], box_width[166:144],
	// box_height[189:167], zero padding[191:190]
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// entry_fraction[16:0], hit_x[40:17], hit_y[64:41], zero padding[71:65]
	output logic [71:0]  m_tdata,
	// hit[0]
	output logic         m_tuser
);

	logic   a_valid, a_ready, b_valid, b_ready, c_valid, c_ready;
	geom_t  a_geom, b_geom, c_geom;
	ratio_t a_lo, a_hi, b_lo;
	logic   a_ok;
	slab_t  a_slab;
	logic   b_hit, c_hit;
	logic [FRAC_W-1:0] c_quo;
	logic [FRAC_W-1:0] entry_fraction;
	logic signed [COORD_W-1:0] hit_x, hit_y;

	sbsc_slab u_slab (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.start_x      (s_tdata[23:0]),
		.start_y      (s_tdata[47:24]),
		.end_x        (s_tdata[71:48]),
		.end_y        (s_tdata[95:72]),
		.box_center_x (s_tdata[119:96]),
		.box_center_y (s_tdata[143:120]),
		.box_width    (s_tdata[166:144]),
		.box_height   (s_tdata[189:167]),
		.out_valid    (a_valid),
		.out_ready    (a_ready),
		.geom         (a_geom),
		.lo           (a_lo),
		.hi           (a_hi),
		.ok_x         (a_ok),
		.slab_y       (a_slab)
	);

	sbsc_yclip u_yclip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid),
		.in_ready  (a_ready),
		.geom_in   (a_geom),
		.lo_in     (a_lo),
		.hi_in     (a_hi),
		.ok_x      (a_ok),
		.slab_y    (a_slab),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.geom      (b_geom),
		.lo        (b_lo),
		.hit       (b_hit)
	);

	sbsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.geom_in   (b_geom),
		.lo        (b_lo),
		.hit_in    (b_hit),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.geom      (c_geom),
		.quo       (c_quo),
		.hit       (c_hit)
	);

	sbsc_point u_point (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (c_valid),
		.in_ready       (c_ready),
		.geom           (c_geom),
		.quo            (c_quo),
		.hit_in         (c_hit),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.hit            (m_tuser),
		.entry_fraction (entry_fraction),
		.hit_x          (hit_x),
		.hit_y          (hit_y)
	);

	assign m_tdata = {7'd0, hit_y, hit_x, entry_fraction};

endmodule

// File: src/sbsc_checker.sv
// ----------------------------------------------------------------------------
// sbsc_checker
// Port-level checks of the segment versus box clipping core.
// ----------------------------------------------------------------------------
module sbsc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [71:0]  m_tdata,
	input logic         m_tuser
);

	// A waiting result stays offered until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn before transfer");

	// A miss carries no fraction and no entry point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[64:0] == 65'd0)
		else $error("miss with non-zero result fields");

	// The entry fraction never exceeds one.
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[16:0] <= 17'd65536)
		else $error("entry fraction above one");

	// The padding above the fields is always zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] == 7'd0)
		else $error("non-zero padding in result");

endmodule

bind segment_box_slab_clip_core sbsc_checker u_sbsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
